/* rtl/pgsd_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pgsd_pkg
// shared types, constants and helpers of the scan and flood detector
// ---------------------------------------------------------------------------
package pgsd_pkg;

    localparam int TRACKER_ENTRIES = 32;
    localparam int TIME_BITS       = 48;
    localparam int IDX_BITS        = (TRACKER_ENTRIES > 1) ? $clog2(TRACKER_ENTRIES) : 1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] FLAG_SYN  = 8'h02;
    localparam logic [7:0] FLAG_ACK  = 8'h10;

    // configuration register indexes
    localparam logic [3:0] CFG_BLOCK_EN   = 4'd0;
    localparam logic [3:0] CFG_SCAN_THR   = 4'd1;
    localparam logic [3:0] CFG_FLOOD_THR  = 4'd2;
    localparam logic [3:0] CFG_WINDOW_LEN = 4'd3;
    localparam logic [3:0] CFG_GRACE_LEN  = 4'd4;
    localparam logic [3:0] CFG_SUBNET     = 4'd5;
    localparam logic [3:0] CFG_MASK       = 4'd6;
    localparam logic [3:0] CFG_GATEWAY    = 4'd7;

    typedef enum logic [1:0] {
        ST_TRACKED   = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_UNTRACKED = 2'd2
    } t_status;

    typedef struct packed {
        logic        block_en;
        logic [15:0] scan_thr;
        logic [15:0] flood_thr;
        logic [31:0] window_len;
        logic [31:0] grace_len;
        logic [31:0] subnet;
        logic [31:0] mask;
        logic [31:0] gateway;
    } t_cfg;

    // classified packet event passed from front to back
    typedef struct packed {
        t_status              status;
        logic                 internal;
        logic                 pure_syn;
        logic                 count_flow;
        logic [31:0]          src;
        logic [31:0]          dst;
        logic [TIME_BITS-1:0] now;
    } t_item;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (&v) ? v : v + 16'd1;
    endfunction

endpackage
`default_nettype wire

/* rtl/pgsd_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pgsd_front
// accepts packet events, classifies them and queues them for the tracker
// ---------------------------------------------------------------------------
module pgsd_front import pgsd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_source_address,
    input  wire logic [31:0] i_dest_address,
    input  wire logic [7:0]  i_protocol_number,
    input  wire logic [7:0]  i_tcp_flag_bits,
    input  wire logic        i_flow_is_new,
    input  wire logic        i_source_blocked,
    input  wire logic [47:0] i_time_us,
    output logic             o_q_valid,
    output t_item            o_q_item,
    input  wire logic        i_q_pop
);

    t_item      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_item      cls;
    logic       drop;
    logic       untracked;
    logic       pure_syn;
    logic       push;

    // source classification
    always_comb begin
        drop = (i_source_address[7:0] == 8'h7F) || (i_source_address == i_cfg.gateway)
            || (i_source_address == 32'd0) || (&i_source_address) || i_source_blocked;
        untracked = (i_source_address[15:0] == 16'hFEA9) || (i_source_address[7:4] == 4'hE);
        pure_syn = (i_protocol_number == PROTO_TCP) && ((i_tcp_flag_bits & FLAG_SYN) != 8'd0)
            && ((i_tcp_flag_bits & FLAG_ACK) == 8'd0);
        cls.status     = drop ? ST_DROPPED : (untracked ? ST_UNTRACKED : ST_TRACKED);
        cls.internal   = (i_source_address & i_cfg.mask) == i_cfg.subnet;
        cls.pure_syn   = pure_syn;
        cls.count_flow = i_flow_is_new && (pure_syn || (i_protocol_number == PROTO_UDP));
        cls.src        = i_source_address;
        cls.dst        = i_dest_address;
        cls.now        = TIME_BITS'(i_time_us);
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rd];

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wr] <= cls;
                r_wr      <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/pgsd_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pgsd_back
// per-source tracker table: match, allocate, window update and alerts
// ---------------------------------------------------------------------------
module pgsd_back import pgsd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_q_valid,
    input  wire t_item       i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic             o_scan_alert,
    output logic             o_flood_alert,
    output logic             o_block_request,
    output logic             o_attacker_internal,
    output logic [31:0]      o_alert_target,
    output logic [15:0]      o_flow_count,
    output logic [15:0]      o_syn_total
);

    typedef enum logic [2:0] {S_IDLE, S_MATCH, S_SCAN, S_LOAD, S_WRITE} t_state;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TRACKER_ENTRIES - 1);

    // tracker table
    logic [31:0]          r_addr  [TRACKER_ENTRIES];
    logic [31:0]          r_dest  [TRACKER_ENTRIES];
    logic [TIME_BITS-1:0] r_wsa   [TRACKER_ENTRIES];
    logic [TIME_BITS-1:0] r_gea   [TRACKER_ENTRIES];
    logic [15:0]          r_flowa [TRACKER_ENTRIES];
    logic [15:0]          r_syna  [TRACKER_ENTRIES];
    logic                 r_sfa   [TRACKER_ENTRIES];
    logic                 r_ffa   [TRACKER_ENTRIES];

    t_state               r_state;
    t_item                r_item;
    logic [IDX_BITS-1:0]  r_idx;
    logic [IDX_BITS-1:0]  r_scan_i;
    logic [TIME_BITS-1:0] r_best_ws;
    logic                 r_new;
    logic [TIME_BITS-1:0] r_ws;
    logic [TIME_BITS-1:0] r_ge;
    logic [15:0]          r_flow;
    logic [15:0]          r_syn;
    logic                 r_sf;
    logic                 r_ff;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic                 r_out_scan;
    logic                 r_out_flood;
    logic                 r_out_block;
    logic                 r_out_int;
    logic [31:0]          r_out_dest;
    logic [15:0]          r_out_flow;
    logic [15:0]          r_out_syn;

    logic                 out_free;
    logic                 match_any;
    logic                 free_any;
    logic [IDX_BITS-1:0]  match_idx;
    logic [IDX_BITS-1:0]  vacant_idx;
    logic [TIME_BITS:0]   grace_sum;
    logic [TIME_BITS-1:0] grace_end;
    logic [TIME_BITS-1:0] elapsed;
    logic                 restart;
    logic [15:0]          n_flow;
    logic [15:0]          n_syn;
    logic                 past_grace;
    logic                 scan;
    logic                 flood;

    assign out_free = !r_out_valid || i_out_ready;

    // pop dropped and untracked items once the result slot frees, tracked items at once
    always_comb begin
        o_q_pop = 1'b0;
        if (r_state == S_IDLE && i_q_valid) begin
            o_q_pop = (i_q_item.status == ST_TRACKED) ? 1'b1 : out_free;
        end
    end

    // parallel match and first free entry, lowest index wins
    always_comb begin
        match_any  = 1'b0;
        free_any   = 1'b0;
        match_idx  = '0;
        vacant_idx = '0;
        for (int i = TRACKER_ENTRIES - 1; i >= 0; i--) begin
            if (r_addr[i] == r_item.src) begin
                match_any = 1'b1;
                match_idx = IDX_BITS'(i);
            end
            if (r_addr[i] == 32'd0) begin
                free_any   = 1'b1;
                vacant_idx = IDX_BITS'(i);
            end
        end
    end

    // window and grace arithmetic for the selected entry
    always_comb begin
        grace_sum = {1'b0, r_item.now} + (TIME_BITS + 1)'(i_cfg.grace_len);
        grace_end = grace_sum[TIME_BITS] ? TIME_MAX : grace_sum[TIME_BITS-1:0];
        elapsed   = (r_item.now >= r_wsa[r_idx]) ? r_item.now - r_wsa[r_idx] : '0;
        restart   = elapsed > TIME_BITS'(i_cfg.window_len);
    end

    // counter update and alert decision
    always_comb begin
        n_flow     = r_item.count_flow ? sat_inc(r_flow) : r_flow;
        n_syn      = r_item.pure_syn ? sat_inc(r_syn) : r_syn;
        past_grace = r_item.now >= r_ge;
        scan       = past_grace && !r_sf && (n_flow >= i_cfg.scan_thr);
        flood      = past_grace && !r_ff && (n_syn >= i_cfg.flood_thr);
    end

    // sequencer, table and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TRACKER_ENTRIES; i++) begin
                r_addr[i]  <= '0;
                r_dest[i]  <= '0;
                r_wsa[i]   <= '0;
                r_gea[i]   <= '0;
                r_flowa[i] <= '0;
                r_syna[i]  <= '0;
                r_sfa[i]   <= 1'b0;
                r_ffa[i]   <= 1'b0;
            end
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_item.status == ST_TRACKED) begin
                            r_item  <= i_q_item;
                            r_state <= S_MATCH;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= i_q_item.status;
                            r_out_scan   <= 1'b0;
                            r_out_flood  <= 1'b0;
                            r_out_block  <= 1'b0;
                            r_out_int    <= 1'b0;
                            r_out_dest   <= '0;
                            r_out_flow   <= '0;
                            r_out_syn    <= '0;
                        end
                    end
                end
                S_MATCH: begin
                    if (match_any) begin
                        r_idx   <= match_idx;
                        r_new   <= 1'b0;
                        r_state <= S_LOAD;
                    end else if (free_any) begin
                        r_idx   <= vacant_idx;
                        r_new   <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_idx     <= '0;
                        r_new     <= 1'b1;
                        r_best_ws <= r_wsa[0];
                        r_scan_i  <= IDX_BITS'(1);
                        r_state   <= (TRACKER_ENTRIES == 1) ? S_LOAD : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // oldest window start, one entry per cycle
                    if (r_wsa[r_scan_i] < r_best_ws) begin
                        r_idx     <= r_scan_i;
                        r_best_ws <= r_wsa[r_scan_i];
                    end
                    if (r_scan_i == LAST_IDX) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_scan_i <= r_scan_i + IDX_BITS'(1);
                    end
                end
                S_LOAD: begin
                    if (r_new || restart) begin
                        r_ws   <= r_item.now;
                        r_flow <= '0;
                        r_syn  <= '0;
                        r_sf   <= 1'b0;
                        r_ff   <= 1'b0;
                    end else begin
                        r_ws   <= r_wsa[r_idx];
                        r_flow <= r_flowa[r_idx];
                        r_syn  <= r_syna[r_idx];
                        r_sf   <= r_sfa[r_idx];
                        r_ff   <= r_ffa[r_idx];
                    end
                    r_ge    <= r_new ? grace_end : r_gea[r_idx];
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (out_free) begin
                        r_addr[r_idx]  <= r_item.src;
                        r_dest[r_idx]  <= r_item.dst;
                        r_wsa[r_idx]   <= r_ws;
                        r_gea[r_idx]   <= r_ge;
                        r_flowa[r_idx] <= n_flow;
                        r_syna[r_idx]  <= n_syn;
                        r_sfa[r_idx]   <= r_sf || scan;
                        r_ffa[r_idx]   <= r_ff || flood;
                        r_out_valid    <= 1'b1;
                        r_out_status   <= ST_TRACKED;
                        r_out_scan     <= scan;
                        r_out_flood    <= flood;
                        r_out_block    <= (scan || flood) && i_cfg.block_en;
                        r_out_int      <= r_item.internal;
                        r_out_dest     <= r_item.dst;
                        r_out_flow     <= n_flow;
                        r_out_syn      <= n_syn;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_scan_alert        = r_out_scan;
    assign o_flood_alert       = r_out_flood;
    assign o_block_request     = r_out_block;
    assign o_attacker_internal = r_out_int;
    assign o_alert_target      = r_out_dest;
    assign o_flow_count        = r_out_flow;
    assign o_syn_total         = r_out_syn;

endmodule
`default_nettype wire

/* rtl/portscan_synflood_detector.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// portscan_synflood_detector
// per-source port-scan and SYN-flood rate detector
// ---------------------------------------------------------------------------
// One result per packet event, in order. A two-entry queue decouples input
// acceptance from the tracker. Dropped and untracked sources are answered at
// pop once the result slot is free; a tracked source goes through pop, parallel
// match over the 32-entry table, window load and write-back, which waits for a
// free result slot, plus a linear walk for the oldest window when the source
// is new and the table is full. Configuration writes are taken in every cycle.
module portscan_synflood_detector import pgsd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_source_address,
    input  wire logic [31:0] i_dest_address,
    input  wire logic [7:0]  i_protocol_number,
    input  wire logic [7:0]  i_tcp_flag_bits,
    input  wire logic        i_flow_is_new,
    input  wire logic        i_source_blocked,
    input  wire logic [47:0] i_time_us,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic             o_scan_alert,
    output logic             o_flood_alert,
    output logic             o_block_request,
    output logic             o_attacker_internal,
    output logic [31:0]      o_alert_target,
    output logic [15:0]      o_flow_count,
    output logic [15:0]      o_syn_total
);

    t_cfg  r_cfg;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_en   <= 1'b0;
            r_cfg.scan_thr   <= 16'd120;
            r_cfg.flood_thr  <= 16'd200;
            r_cfg.window_len <= 32'd10000000;
            r_cfg.grace_len  <= 32'd30000000;
            r_cfg.subnet     <= 32'h0004A8C0;
            r_cfg.mask       <= 32'h00FFFFFF;
            r_cfg.gateway    <= 32'h0104A8C0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BLOCK_EN:   r_cfg.block_en   <= i_cfg_data[0];
                CFG_SCAN_THR:   r_cfg.scan_thr   <= i_cfg_data[15:0];
                CFG_FLOOD_THR:  r_cfg.flood_thr  <= i_cfg_data[15:0];
                CFG_WINDOW_LEN: r_cfg.window_len <= i_cfg_data;
                CFG_GRACE_LEN:  r_cfg.grace_len  <= i_cfg_data;
                CFG_SUBNET:     r_cfg.subnet     <= i_cfg_data;
                CFG_MASK:       r_cfg.mask       <= i_cfg_data;
                CFG_GATEWAY:    r_cfg.gateway    <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    pgsd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_source_address  (i_source_address),
        .i_dest_address    (i_dest_address),
        .i_protocol_number (i_protocol_number),
        .i_tcp_flag_bits   (i_tcp_flag_bits),
        .i_flow_is_new     (i_flow_is_new),
        .i_source_blocked  (i_source_blocked),
        .i_time_us         (i_time_us),
        .o_q_valid         (q_valid),
        .o_q_item          (q_item),
        .i_q_pop           (q_pop)
    );

    pgsd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_q_valid           (q_valid),
        .i_q_item            (q_item),
        .o_q_pop             (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_scan_alert        (o_scan_alert),
        .o_flood_alert       (o_flood_alert),
        .o_block_request     (o_block_request),
        .o_attacker_internal (o_attacker_internal),
        .o_alert_target      (o_alert_target),
        .o_flow_count        (o_flow_count),
        .o_syn_total         (o_syn_total)
    );

endmodule
`default_nettype wire
